// ===== rtl/core/pngcsc_pkg.sv =====
// ---------------------------------------------------------------------------
// pngcsc_pkg
// Shared types, constants and the byte-wide CRC-32 update for the PNG chunk
// stream checker.
// ---------------------------------------------------------------------------
package pngcsc_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0] CrcPreset   = 32'hFFFF_FFFF;
  localparam logic [31:0] IendWord    = 32'h4945_4E44;
  localparam logic [31:0] LimitReset  = 32'd2147483646;
  localparam logic [31:0] SigBytes    = 32'd8;
  localparam logic [31:0] WordBytes   = 32'd4;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_EOS  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BADSIG = 3'd1,
    ST_OVER   = 3'd2,
    ST_CRC    = 3'd3,
    ST_TRUNC  = 3'd4
  } status_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_value;
  } req_t;

  typedef struct packed {
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [31:0] stored_crc;
    logic [2:0]  status;
    logic        is_last;
  } rsp_t;

  // classified entry held in the queue between front and back
  typedef struct packed {
    op_t        op;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h89;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      3'd7:    val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/pngcsc_front.sv =====
// ---------------------------------------------------------------------------
// pngcsc_front
// Input stage: takes byte transactions, classifies them and hands them on
// to the queue.
// ---------------------------------------------------------------------------
module pngcsc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pngcsc_pkg::req_t      in_data,
  input  pngcsc_pkg::q_status_t q_status,
  output logic                  push,
  output pngcsc_pkg::item_t     push_item
);

  logic              f_valid;
  logic              f_valid_next;
  pngcsc_pkg::item_t f_item;
  logic              accept;

  assign push     = f_valid && !q_status.full;
  assign in_stall = f_valid && q_status.full;
  assign accept   = in_valid && !in_stall;

  assign f_valid_next = accept || (f_valid && !push);
  assign push_item    = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item.op         <= in_data.req_type ? pngcsc_pkg::OP_EOS : pngcsc_pkg::OP_BYTE;
      f_item.byte_value <= in_data.byte_value;
    end
  end

endmodule

// ===== rtl/core/pngcsc_queue.sv =====
// ---------------------------------------------------------------------------
// pngcsc_queue
// Short fifo between the front and back parts.
// ---------------------------------------------------------------------------
module pngcsc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pngcsc_pkg::item_t     push_item,
  input  logic                  pop,
  output pngcsc_pkg::item_t     pop_item,
  output pngcsc_pkg::q_status_t q_status
);

  localparam int unsigned PtrW = pngcsc_pkg::QueuePtrW;
  localparam int unsigned CntW = PtrW + 1;

  pngcsc_pkg::item_t entries [pngcsc_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign q_status.full  = (count == CntW'(pngcsc_pkg::QueueDepth));
  assign q_status.empty = (count == '0);
  assign pop_item       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/pngcsc_back.sv =====
// ---------------------------------------------------------------------------
// pngcsc_back
// Chunk parser: signature check, length/type/data/crc sections, crc-32 and
// the registered report output.
// ---------------------------------------------------------------------------
module pngcsc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  pngcsc_pkg::q_status_t q_status,
  input  pngcsc_pkg::item_t     pop_item,
  output logic                  pop,
  input  logic                  cfg_wr_en,
  input  logic [31:0]           cfg_wr_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pngcsc_pkg::rsp_t      out_data
);

  pngcsc_pkg::phase_t phase, phase_next;
  logic [31:0]        byte_count, byte_count_next;
  logic               signature_bad, signature_bad_next;
  logic [31:0]        length_word, length_word_next;
  logic [31:0]        type_word, type_word_next;
  logic [31:0]        received_crc, received_crc_next;
  logic [31:0]        running_crc, running_crc_next;
  logic [31:0]        length_limit;
  logic               out_valid_next;
  pngcsc_pkg::rsp_t   out_data_next;

  logic               emit;
  logic [31:0]        cnt1;
  logic [7:0]         b;
  logic               bad;
  logic [31:0]        len_sh;
  logic [31:0]        crc_sh;
  logic [31:0]        crc_upd;

  // output register is free or being taken this cycle
  assign pop = !q_status.empty && (!out_valid || !out_stall);

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    signature_bad_next = signature_bad;
    length_word_next   = length_word;
    type_word_next     = type_word;
    received_crc_next  = received_crc;
    running_crc_next   = running_crc;
    emit               = 1'b0;
    out_data_next      = out_data;

    b       = pop_item.byte_value;
    cnt1    = byte_count + 32'd1;
    bad     = signature_bad || (b != pngcsc_pkg::sig_byte(byte_count[2:0]));
    len_sh  = {length_word[23:0], b};
    crc_sh  = {received_crc[23:0], b};
    crc_upd = pngcsc_pkg::crc_byte(running_crc, b);

    if (pop) begin
      if (pop_item.op == pngcsc_pkg::OP_EOS) begin
        if (phase != pngcsc_pkg::PH_DONE) begin
          emit                       = 1'b1;
          out_data_next.chunk_type   = type_word;
          out_data_next.chunk_length = length_word;
          out_data_next.stored_crc   = received_crc;
          out_data_next.status       = pngcsc_pkg::ST_TRUNC;
          out_data_next.is_last      = 1'b1;
        end
        phase_next         = pngcsc_pkg::PH_SIG;
        byte_count_next    = '0;
        signature_bad_next = 1'b0;
        length_word_next   = '0;
        type_word_next     = '0;
        received_crc_next  = '0;
        running_crc_next   = pngcsc_pkg::CrcPreset;
      end else begin
        case (phase)
          pngcsc_pkg::PH_SIG: begin
            if (cnt1 >= pngcsc_pkg::SigBytes) begin
              byte_count_next = '0;
              if (bad) begin
                phase_next                 = pngcsc_pkg::PH_DONE;
                emit                       = 1'b1;
                out_data_next.chunk_type   = '0;
                out_data_next.chunk_length = '0;
                out_data_next.stored_crc   = '0;
                out_data_next.status       = pngcsc_pkg::ST_BADSIG;
                out_data_next.is_last      = 1'b1;
              end else begin
                phase_next        = pngcsc_pkg::PH_LEN;
                length_word_next  = '0;
                type_word_next    = '0;
                received_crc_next = '0;
                running_crc_next  = pngcsc_pkg::CrcPreset;
              end
            end else begin
              byte_count_next    = cnt1;
              signature_bad_next = bad;
            end
          end
          pngcsc_pkg::PH_LEN: begin
            length_word_next = len_sh;
            if (cnt1 >= pngcsc_pkg::WordBytes) begin
              byte_count_next = '0;
              if (len_sh > length_limit) begin
                phase_next                 = pngcsc_pkg::PH_DONE;
                emit                       = 1'b1;
                out_data_next.chunk_type   = '0;
                out_data_next.chunk_length = len_sh;
                out_data_next.stored_crc   = '0;
                out_data_next.status       = pngcsc_pkg::ST_OVER;
                out_data_next.is_last      = 1'b1;
              end else begin
                phase_next = pngcsc_pkg::PH_TYPE;
              end
            end else begin
              byte_count_next = cnt1;
            end
          end
          pngcsc_pkg::PH_TYPE: begin
            type_word_next   = {type_word[23:0], b};
            running_crc_next = crc_upd;
            if (cnt1 >= pngcsc_pkg::WordBytes) begin
              byte_count_next = '0;
              // zero-length chunk goes straight to its crc
              phase_next = (length_word == '0) ? pngcsc_pkg::PH_CRC : pngcsc_pkg::PH_DATA;
            end else begin
              byte_count_next = cnt1;
            end
          end
          pngcsc_pkg::PH_DATA: begin
            running_crc_next = crc_upd;
            if (cnt1 >= length_word) begin
              byte_count_next = '0;
              phase_next      = pngcsc_pkg::PH_CRC;
            end else begin
              byte_count_next = cnt1;
            end
          end
          pngcsc_pkg::PH_CRC: begin
            received_crc_next = crc_sh;
            if (cnt1 >= pngcsc_pkg::WordBytes) begin
              emit                       = 1'b1;
              out_data_next.chunk_type   = type_word;
              out_data_next.chunk_length = length_word;
              out_data_next.stored_crc   = crc_sh;
              if (crc_sh != ~running_crc) begin
                phase_next            = pngcsc_pkg::PH_DONE;
                byte_count_next       = '0;
                out_data_next.status  = pngcsc_pkg::ST_CRC;
                out_data_next.is_last = 1'b1;
              end else if (type_word == pngcsc_pkg::IendWord) begin
                phase_next            = pngcsc_pkg::PH_DONE;
                byte_count_next       = '0;
                out_data_next.status  = pngcsc_pkg::ST_OK;
                out_data_next.is_last = 1'b1;
              end else begin
                // next chunk
                phase_next            = pngcsc_pkg::PH_LEN;
                byte_count_next       = '0;
                length_word_next      = '0;
                type_word_next        = '0;
                received_crc_next     = '0;
                running_crc_next      = pngcsc_pkg::CrcPreset;
                out_data_next.status  = pngcsc_pkg::ST_OK;
                out_data_next.is_last = 1'b0;
              end
            end else begin
              byte_count_next = cnt1;
            end
          end
          default: begin
            // finished stream: bytes are dropped until end of stream
          end
        endcase
      end
    end

    out_valid_next = pop ? emit : (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= pngcsc_pkg::PH_SIG;
      byte_count    <= '0;
      signature_bad <= 1'b0;
      length_word   <= '0;
      type_word     <= '0;
      received_crc  <= '0;
      running_crc   <= pngcsc_pkg::CrcPreset;
      length_limit  <= pngcsc_pkg::LimitReset;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      signature_bad <= signature_bad_next;
      length_word   <= length_word_next;
      type_word     <= type_word_next;
      received_crc  <= received_crc_next;
      running_crc   <= running_crc_next;
      out_valid     <= out_valid_next;
      if (cfg_wr_en) begin
        length_limit <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data <= out_data_next;
    end
  end

endmodule

// ===== rtl/core/png_chunk_stream_checker.sv =====
// ---------------------------------------------------------------------------
// png_chunk_stream_checker
// PNG signature and chunk checker with CRC-32, one byte per cycle while no report is held by out_stall.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): one transaction per file
// byte (req_type 0) or one end-of-stream marker (req_type 1), which ends the
// file and returns the parser to the signature phase.
// Output channel (out_valid / out_stall / out_data): one report per chunk
// with its type, length, received CRC and status; errors and IEND set
// is_last, after which bytes are dropped until end of stream. An unfinished
// stream gives a truncated report at its end-of-stream marker.
// Configuration: cfg_wr_en / cfg_wr_data write length_limit, the largest
// accepted chunk length; write it only while the block is idle.
// Throughput: one byte per cycle unless out_stall holds a report, set by the
// byte-wide CRC update in the back part. The byte completing a report passes
// the input register, then the queue, then the registered report output.
// When out_stall is high with a report valid, the report holds, the back part
// stops, and the four-entry queue and input register fill before in_stall rises.
// Reset (rst, synchronous) empties the queue and the output, returns to the
// signature phase and sets length_limit to 2147483646.
// ---------------------------------------------------------------------------
module png_chunk_stream_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pngcsc_pkg::req_t      in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pngcsc_pkg::rsp_t      out_data,
  input  logic                  cfg_wr_en,
  input  logic [31:0]           cfg_wr_data
);

  pngcsc_pkg::q_status_t q_status;
  logic                  push;
  logic                  pop;
  pngcsc_pkg::item_t     push_item;
  pngcsc_pkg::item_t     pop_item;

  pngcsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  pngcsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  pngcsc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .pop_item    (pop_item),
    .pop         (pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
